// File: design/rse_pkg.sv
package rse_pkg;

   localparam int unsigned VAL_W    = 32;
   localparam int unsigned FRAC_W   = 16;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned DEPTH_W  = 7;

   localparam int unsigned CMDQ_DEPTH = 2;
   localparam int unsigned CMDQ_AW    = 1;
   localparam int unsigned CMDQ_CW    = 2;

   localparam logic [VAL_W-1:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [VAL_W-1:0] Q_MIN = 32'h8000_0000;

   typedef enum logic [1:0] {
      MODE_PUSH   = 2'd0,
      MODE_OPER   = 2'd1,
      MODE_FINISH = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_FEW   = 3'd1,
      ST_FULL  = 3'd2,
      ST_DIV0  = 3'd3,
      ST_EMPTY = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_MULT = 2'd2,
      S_DIVW = 2'd3
   } state_type;

   typedef struct packed {
      mode_type          mode;
      op_type            op;
      logic [VAL_W-1:0]  value;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_chan_type;

   typedef struct packed {
      logic             start;
      logic [VAL_W-1:0] dividend;
      logic [VAL_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [VAL_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic [VAL_W-1:0] sat48(input logic [47:0] v);
      logic [VAL_W-1:0] r;
      if (!v[47] && (|v[46:31])) begin
         r = Q_MAX;
      end else if (v[47] && !(&v[46:31])) begin
         r = Q_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// File: design/rse_front.sv
module rse_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [1:0]                 req_mode,
   input  logic signed [31:0]         req_number_value,
   input  logic [1:0]                 req_operator_code,
   output rse_pkg::cmd_chan_type      cmd_out,
   input  logic                       cmd_pop
);

   rse_pkg::cmd_type                    entry_ff [rse_pkg::CMDQ_DEPTH];
   logic [rse_pkg::CMDQ_AW-1:0]         wr_ptr_ff;
   logic [rse_pkg::CMDQ_AW-1:0]         rd_ptr_ff;
   logic [rse_pkg::CMDQ_CW-1:0]         count_ff;
   logic [rse_pkg::CMDQ_CW-1:0]         count_in;
   rse_pkg::cmd_type                    cmd_new;
   logic                                do_push;
   logic                                do_pop;

   always_comb begin
      cmd_new.mode  = rse_pkg::mode_type'(req_mode);
      cmd_new.op    = rse_pkg::op_type'(req_operator_code);
      cmd_new.value = '0;
      case (cmd_new.mode)
         rse_pkg::MODE_PUSH: cmd_new.value = req_number_value;
         rse_pkg::MODE_OPER: cmd_new.value = '0;
         default:            cmd_new.value = '0;
      endcase
   end

   assign req_full      = (count_ff == rse_pkg::CMDQ_CW'(rse_pkg::CMDQ_DEPTH));
   assign do_push       = req_push && !req_full;
   assign do_pop        = cmd_pop && (count_ff != '0);
   assign cmd_out.valid = (count_ff != '0);
   assign cmd_out.cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + rse_pkg::CMDQ_CW'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - rse_pkg::CMDQ_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + rse_pkg::CMDQ_AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + rse_pkg::CMDQ_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// File: design/rse_div.sv
module rse_div (
   input  logic                  clock,
   input  logic                  reset,
   input  rse_pkg::div_req_type  div_req,
   output rse_pkg::div_rsp_type  div_rsp
);

   localparam int unsigned STEPS = rse_pkg::VAL_W;
   localparam int unsigned CNT_W = $clog2(STEPS + 1);

   logic [rse_pkg::VAL_W-1:0] rem_ff;
   logic [rse_pkg::VAL_W-1:0] quo_ff;
   logic [rse_pkg::VAL_W-1:0] dvs_ff;
   logic                      neg_ff;
   logic                      ovf_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic                      done_ff;

   logic [rse_pkg::VAL_W-1:0] mag_a;
   logic [rse_pkg::VAL_W-1:0] mag_b;
   logic [rse_pkg::VAL_W:0]   trial;
   logic                      ge;
   logic [rse_pkg::VAL_W-1:0] rem_in;
   logic [rse_pkg::VAL_W-1:0] result;

   assign mag_a = div_req.dividend[31] ? (~div_req.dividend + 32'd1) : div_req.dividend;
   assign mag_b = div_req.divisor[31]  ? (~div_req.divisor  + 32'd1) : div_req.divisor;

   assign trial  = {rem_ff, quo_ff[31]};
   assign ge     = (trial >= {1'b0, dvs_ff});
   assign rem_in = ge ? 32'(trial - {1'b0, dvs_ff}) : trial[31:0];

   always_comb begin
      if (ovf_ff) begin
         result = neg_ff ? rse_pkg::Q_MIN : rse_pkg::Q_MAX;
      end else if (neg_ff) begin
         result = (quo_ff > rse_pkg::Q_MIN) ? rse_pkg::Q_MIN : (~quo_ff + 32'd1);
      end else begin
         result = quo_ff[31] ? rse_pkg::Q_MAX : quo_ff;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = result;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (div_req.start) begin
         cnt_ff  <= CNT_W'(STEPS);
         done_ff <= 1'b0;
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= {16'd0, mag_a[31:16]};
         quo_ff <= {mag_a[15:0], 16'd0};
         dvs_ff <= mag_b;
         neg_ff <= div_req.dividend[31] ^ div_req.divisor[31];
         ovf_ff <= ({16'd0, mag_a[31:16]} >= mag_b);
      end else if (cnt_ff != '0) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[30:0], ge};
      end
   end

`ifndef ASSERT_OFF
   a_busy_not_done: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> !done_ff)
      else $error("divider reports done while still iterating");
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> (!done_ff && cnt_ff == CNT_W'(STEPS)))
      else $error("divider start did not restart the iteration");
   a_done_after_steps: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == CNT_W'(1) && !div_req.start) |=> done_ff)
      else $error("divider missed its final step");
`endif

endmodule

// File: design/rse_back.sv
module rse_back #(
   parameter int unsigned STACK_DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  rse_pkg::cmd_chan_type      cmd_in,
   output logic                       cmd_pop,
   output rse_pkg::div_req_type       div_req,
   input  rse_pkg::div_rsp_type       div_rsp,
   output logic                       out_valid,
   input  logic                       out_pop,
   output logic [2:0]                 out_status,
   output logic [31:0]                out_top,
   output logic [6:0]                 out_depth
);

   localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
   localparam int unsigned AW  = $clog2(STACK_DEPTH);

   logic [rse_pkg::VAL_W-1:0] mem [STACK_DEPTH];

   rse_pkg::state_type        state_ff;
   rse_pkg::state_type        state_in;
   logic [SPW-1:0]            sp_ff;
   logic [SPW-1:0]            sp_in;
   logic [rse_pkg::VAL_W-1:0] top_ff;
   logic [rse_pkg::VAL_W-1:0] top_in;
   logic [rse_pkg::VAL_W-1:0] rd_data_ff;
   rse_pkg::op_type           op_ff;
   logic signed [63:0]        prod_ff;

   logic                      out_valid_ff;
   rse_pkg::status_type       out_status_ff;
   logic [rse_pkg::VAL_W-1:0] out_top_ff;
   logic [rse_pkg::DEPTH_W-1:0] out_depth_ff;

   logic                      out_free;
   logic                      rd_en;
   logic                      wr_en;
   logic                      load_out;
   rse_pkg::status_type       res_status;
   logic [rse_pkg::VAL_W-1:0] res_top;
   logic [SPW-1:0]            sp_m1;
   logic [SPW-1:0]            sp_m2;
   logic                      sp_zero;
   logic                      sp_full;
   logic                      sp_few;
   logic [rse_pkg::VAL_W-1:0] top_or_zero;
   logic [47:0]               add_wide;
   logic [47:0]               sub_wide;
   logic [63:0]               mul_adj;
   logic [rse_pkg::VAL_W-1:0] add_sat;
   logic [rse_pkg::VAL_W-1:0] sub_sat;
   logic [rse_pkg::VAL_W-1:0] mul_sat;
   logic                      b_zero;

   assign out_free    = !out_valid_ff || out_pop;
   assign sp_m1       = sp_ff - SPW'(1);
   assign sp_m2       = sp_ff - SPW'(2);
   assign sp_zero     = (sp_ff == '0);
   assign sp_full     = (sp_ff == SPW'(STACK_DEPTH));
   assign sp_few      = (sp_ff < SPW'(2));
   assign top_or_zero = sp_zero ? '0 : top_ff;
   assign b_zero      = (top_ff == '0);

   assign add_wide = {{16{rd_data_ff[31]}}, rd_data_ff} + {{16{top_ff[31]}}, top_ff};
   assign sub_wide = {{16{rd_data_ff[31]}}, rd_data_ff} - {{16{top_ff[31]}}, top_ff};
   assign mul_adj  = prod_ff + (prod_ff[63] ? 64'sd65535 : 64'sd0);
   assign add_sat  = rse_pkg::sat48(add_wide);
   assign sub_sat  = rse_pkg::sat48(sub_wide);
   assign mul_sat  = rse_pkg::sat48(mul_adj[63:16]);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rse_pkg::S_IDLE: begin
            if (cmd_in.valid && out_free && cmd_in.cmd.mode == rse_pkg::MODE_OPER && !sp_few) begin
               state_in = rse_pkg::S_EXEC;
            end
         end
         rse_pkg::S_EXEC: begin
            case (op_ff)
               rse_pkg::OP_MUL: state_in = rse_pkg::S_MULT;
               rse_pkg::OP_DIV: begin
                  if (!b_zero) begin
                     state_in = rse_pkg::S_DIVW;
                  end else if (out_free) begin
                     state_in = rse_pkg::S_IDLE;
                  end
               end
               default: begin
                  if (out_free) begin
                     state_in = rse_pkg::S_IDLE;
                  end
               end
            endcase
         end
         rse_pkg::S_MULT: begin
            if (out_free) begin
               state_in = rse_pkg::S_IDLE;
            end
         end
         rse_pkg::S_DIVW: begin
            if (div_rsp.done && out_free) begin
               state_in = rse_pkg::S_IDLE;
            end
         end
         default: state_in = rse_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop          = 1'b0;
      rd_en            = 1'b0;
      wr_en            = 1'b0;
      load_out         = 1'b0;
      res_status       = rse_pkg::ST_OK;
      res_top          = top_or_zero;
      top_in           = top_ff;
      sp_in            = sp_ff;
      div_req.start    = 1'b0;
      div_req.dividend = rd_data_ff;
      div_req.divisor  = top_ff;
      case (state_ff)
         rse_pkg::S_IDLE: begin
            if (cmd_in.valid && out_free) begin
               cmd_pop = 1'b1;
               case (cmd_in.cmd.mode)
                  rse_pkg::MODE_PUSH: begin
                     load_out = 1'b1;
                     if (sp_full) begin
                        res_status = rse_pkg::ST_FULL;
                     end else begin
                        wr_en   = !sp_zero;
                        top_in  = cmd_in.cmd.value;
                        sp_in   = sp_ff + SPW'(1);
                        res_top = cmd_in.cmd.value;
                     end
                  end
                  rse_pkg::MODE_OPER: begin
                     if (sp_few) begin
                        load_out   = 1'b1;
                        res_status = rse_pkg::ST_FEW;
                     end else begin
                        rd_en = 1'b1;
                     end
                  end
                  rse_pkg::MODE_FINISH: begin
                     load_out = 1'b1;
                     if (sp_zero) begin
                        res_status = rse_pkg::ST_EMPTY;
                     end else begin
                        sp_in = '0;
                     end
                  end
                  default: load_out = 1'b1;
               endcase
            end
         end
         rse_pkg::S_EXEC: begin
            case (op_ff)
               rse_pkg::OP_ADD: begin
                  if (out_free) begin
                     load_out = 1'b1;
                     top_in   = add_sat;
                     res_top  = add_sat;
                     sp_in    = sp_m1;
                  end
               end
               rse_pkg::OP_SUB: begin
                  if (out_free) begin
                     load_out = 1'b1;
                     top_in   = sub_sat;
                     res_top  = sub_sat;
                     sp_in    = sp_m1;
                  end
               end
               rse_pkg::OP_DIV: begin
                  if (!b_zero) begin
                     div_req.start = 1'b1;
                  end else if (out_free) begin
                     load_out   = 1'b1;
                     res_status = rse_pkg::ST_DIV0;
                  end
               end
               default: ;
            endcase
         end
         rse_pkg::S_MULT: begin
            if (out_free) begin
               load_out = 1'b1;
               top_in   = mul_sat;
               res_top  = mul_sat;
               sp_in    = sp_m1;
            end
         end
         rse_pkg::S_DIVW: begin
            if (div_rsp.done && out_free) begin
               load_out = 1'b1;
               top_in   = div_rsp.quotient;
               res_top  = div_rsp.quotient;
               sp_in    = sp_m1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rse_pkg::S_IDLE;
         sp_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (out_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (rd_en) begin
         op_ff <= cmd_in.cmd.op;
      end
      if (state_ff == rse_pkg::S_EXEC) begin
         prod_ff <= $signed(rd_data_ff) * $signed(top_ff);
      end
      if (load_out) begin
         out_status_ff <= res_status;
         out_top_ff    <= res_top;
         out_depth_ff  <= rse_pkg::DEPTH_W'(sp_in);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[sp_m1[AW-1:0]] <= top_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[sp_m2[AW-1:0]];
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_status = out_status_ff;
   assign out_top    = out_top_ff;
   assign out_depth  = out_depth_ff;

`ifndef ASSERT_OFF
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SPW'(STACK_DEPTH))
      else $error("stack pointer beyond stack depth");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (!out_valid_ff || out_pop))
      else $error("result register overwritten before it was taken");
   a_depth_reported: assert property (@(posedge clock) disable iff (reset)
      load_out |=> (out_depth_ff == rse_pkg::DEPTH_W'(sp_ff)))
      else $error("reported depth differs from stack pointer");
   a_div_launch: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> (state_ff == rse_pkg::S_DIVW && !div_rsp.done))
      else $error("divide started without waiting for the divider");
   a_oper_needs_two: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (sp_ff >= SPW'(2)))
      else $error("operand read with fewer than two values held");
`endif

endmodule

// File: design/rpn_stack_evaluator.sv
// Channel  | Direction | Handshake       | Fields
// req_     | in        | push / full     | mode, number_value, operator_code
// rsp_     | out       | pop / empty     | status, top_value, stack_depth
//
// Push, finish, unused-mode and too-few, full or empty error tokens complete in IDLE in
// the back end once the request queue holds them; add, subtract and a zero divisor go
// on to EXEC, multiply to EXEC and MULT, divide to EXEC and DIVW (the 32-step divider).
// A two-entry request queue lets requests arrive while the back end is busy.
// One result register holds the oldest result until popped; the back end stalls
// when it is occupied and not being popped.
// Synchronous reset empties the stack and both queues; no clearing pass is needed.
module rpn_stack_evaluator #(
   parameter int unsigned STACK_DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [1:0]         req_mode,
   input  logic signed [31:0] req_number_value,
   input  logic [1:0]         req_operator_code,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_top_value,
   output logic [6:0]         rsp_stack_depth
);

   rse_pkg::cmd_chan_type cmd_chan;
   logic                  cmd_pop;
   rse_pkg::div_req_type  div_req;
   rse_pkg::div_rsp_type  div_rsp;
   logic                  out_valid;
   logic [31:0]           out_top;

   rse_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_mode          (req_mode),
      .req_number_value  (req_number_value),
      .req_operator_code (req_operator_code),
      .cmd_out           (cmd_chan),
      .cmd_pop           (cmd_pop)
   );

   rse_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   rse_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_in     (cmd_chan),
      .cmd_pop    (cmd_pop),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .out_valid  (out_valid),
      .out_pop    (rsp_pop),
      .out_status (rsp_status),
      .out_top    (out_top),
      .out_depth  (rsp_stack_depth)
   );

   assign rsp_empty     = !out_valid;
   assign rsp_top_value = $signed(out_top);

endmodule

// File: sim/rpn_stack_evaluator_test.sv
module rpn_stack_evaluator_test;

   localparam int unsigned STACK_SIZE   = 64;
   localparam int unsigned RANDOM_ITEMS = 800;
   localparam int unsigned IDLE_PCT     = 13;
   localparam int unsigned CALM_FROM    = 300;
   localparam int unsigned CALM_TO      = 450;
   localparam int unsigned HOLD_AT      = 600;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_CYCLES = 60;

   typedef struct packed {
      logic [STACK_SIZE-1:0][rse_pkg::VAL_W-1:0] vals;
      int unsigned                               depth;
   } calc_state_type;

   typedef struct packed {
      rse_pkg::status_type         status;
      logic [rse_pkg::VAL_W-1:0]   top;
      logic [rse_pkg::DEPTH_W-1:0] depth;
   } calc_rsp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [1:0]         req_mode = 2'd0;
   logic signed [31:0] req_number_value = '0;
   logic [1:0]         req_operator_code = 2'd0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic [2:0]         rsp_status;
   logic signed [31:0] rsp_top_value;
   logic [6:0]         rsp_stack_depth;

   rse_pkg::cmd_type pending_tokens[$];
   calc_rsp_type     awaited_results[$];
   calc_state_type   plan_state;
   calc_state_type   live_state;
   rse_pkg::cmd_type sent_token;
   calc_rsp_type     want_rsp;
   calc_rsp_type     check_rsp;
   int unsigned      accepted;
   int unsigned      received;
   int unsigned      errors;
   int unsigned      stall_left;
   int unsigned      peak_depth;
   int unsigned      divides;
   int unsigned      status_seen[5];
   bit               hold_done;

   rpn_stack_evaluator #(
      .STACK_DEPTH(STACK_SIZE)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_mode(req_mode),
      .req_number_value(req_number_value),
      .req_operator_code(req_operator_code),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_status(rsp_status),
      .rsp_top_value(rsp_top_value),
      .rsp_stack_depth(rsp_stack_depth)
   );

   always #4 clock = ~clock;

   function automatic logic [rse_pkg::VAL_W-1:0] clamp_q(input longint v);
      logic [rse_pkg::VAL_W-1:0] r;
      if (v > longint'($signed(rse_pkg::Q_MAX))) begin
         r = rse_pkg::Q_MAX;
      end else if (v < longint'($signed(rse_pkg::Q_MIN))) begin
         r = rse_pkg::Q_MIN;
      end else begin
         r = v[rse_pkg::VAL_W-1:0];
      end
      return r;
   endfunction

   function automatic calc_rsp_type evaluate_token(inout calc_state_type s,
                                                   input rse_pkg::cmd_type t);
      calc_rsp_type r;
      longint       a;
      longint       b;
      longint       q;
      r.status = rse_pkg::ST_OK;
      r.top = '0;
      a = 0;
      b = 0;
      q = 0;
      case (t.mode)
         rse_pkg::MODE_PUSH: begin
            if (s.depth >= STACK_SIZE) begin
               r.status = rse_pkg::ST_FULL;
            end else begin
               s.vals[s.depth] = t.value;
               s.depth++;
            end
         end
         rse_pkg::MODE_OPER: begin
            if (s.depth < 2) begin
               r.status = rse_pkg::ST_FEW;
            end else begin
               a = longint'($signed(s.vals[s.depth-2]));
               b = longint'($signed(s.vals[s.depth-1]));
               case (t.op)
                  rse_pkg::OP_ADD: q = a + b;
                  rse_pkg::OP_SUB: q = a - b;
                  rse_pkg::OP_MUL: q = (a * b) / (longint'(1) << rse_pkg::FRAC_W);
                  default: begin
                     if (b == 0) begin
                        r.status = rse_pkg::ST_DIV0;
                     end else begin
                        q = (a * (longint'(1) << rse_pkg::FRAC_W)) / b;
                     end
                  end
               endcase
               if (r.status == rse_pkg::ST_OK) begin
                  s.depth--;
                  s.vals[s.depth-1] = clamp_q(q);
               end
            end
         end
         default: ;
      endcase
      if (t.mode == rse_pkg::MODE_FINISH) begin
         if (s.depth == 0) begin
            r.status = rse_pkg::ST_EMPTY;
         end else begin
            r.top = s.vals[s.depth-1];
            s.depth = 0;
         end
      end else if (s.depth != 0) begin
         r.top = s.vals[s.depth-1];
      end
      r.depth = rse_pkg::DEPTH_W'(s.depth);
      return r;
   endfunction

   function automatic logic [rse_pkg::VAL_W-1:0] pick_number();
      logic [rse_pkg::VAL_W-1:0] v;
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = $urandom_range(0, 1) ? rse_pkg::Q_MAX : rse_pkg::Q_MIN;
         2, 3: v = $urandom;
         4, 5, 6: v = {16'($urandom_range(0, 200) - 100), 16'($urandom)};
         default: v = 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      endcase
      return v;
   endfunction

   task automatic add_token(input rse_pkg::mode_type m, input rse_pkg::op_type o,
                            input logic [rse_pkg::VAL_W-1:0] v);
      rse_pkg::cmd_type t;
      calc_rsp_type     ignored;
      t.mode = m;
      t.op = o;
      t.value = v;
      ignored = evaluate_token(plan_state, t);
      pending_tokens.push_back(t);
   endtask

   function automatic rse_pkg::op_type any_op();
      return rse_pkg::op_type'($urandom_range(0, 3));
   endfunction

   task automatic report_mismatch(input string field, input logic [rse_pkg::VAL_W-1:0] want,
                                  input logic [rse_pkg::VAL_W-1:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
   endtask

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (pending_tokens.size() != 0 &&
                   ((accepted >= CALM_FROM && accepted < CALM_TO) ||
                    $urandom_range(0, 99) >= IDLE_PCT)) begin
         req_push <= 1'b1;
         req_mode <= pending_tokens[0].mode;
         req_operator_code <= pending_tokens[0].op;
         req_number_value <= pending_tokens[0].value;
      end else begin
         req_push <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_push && !req_full) begin
         sent_token.mode = rse_pkg::mode_type'(req_mode);
         sent_token.op = rse_pkg::op_type'(req_operator_code);
         sent_token.value = req_number_value;
         void'(pending_tokens.pop_front());
         want_rsp = evaluate_token(live_state, sent_token);
         awaited_results.push_back(want_rsp);
         status_seen[want_rsp.status]++;
         if (sent_token.mode == rse_pkg::MODE_OPER && sent_token.op == rse_pkg::OP_DIV) begin
            divides++;
         end
         if (live_state.depth > peak_depth) begin
            peak_depth = live_state.depth;
         end
         accepted++;
      end
   end

   // receiver, with one long hold-off to back the block up
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_pop <= 1'b0;
      end else if (received >= HOLD_AT && !hold_done) begin
         stall_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= (received >= CALM_FROM && received < CALM_TO) ||
                    $urandom_range(0, 99) >= IDLE_PCT;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (awaited_results.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected, actual status %0d top %h depth %0d",
                     $time, rsp_status, rsp_top_value, rsp_stack_depth);
         end else begin
            check_rsp = awaited_results.pop_front();
            if (rsp_status != check_rsp.status) begin
               report_mismatch("status", 32'(check_rsp.status), 32'(rsp_status));
            end
            if (rsp_top_value != check_rsp.top) begin
               report_mismatch("top_value", check_rsp.top, rsp_top_value);
            end
            if (rsp_stack_depth != check_rsp.depth) begin
               report_mismatch("stack_depth", 32'(check_rsp.depth), 32'(rsp_stack_depth));
            end
         end
         received++;
      end
   end

   initial begin
      int unsigned scenario;
      int unsigned operands;
      int unsigned pushed;
      int unsigned n;
      plan_state = '0;
      live_state = '0;

      add_token(rse_pkg::MODE_FINISH, rse_pkg::OP_ADD, '0);
      add_token(rse_pkg::MODE_OPER, rse_pkg::OP_ADD, '0);
      add_token(rse_pkg::MODE_NONE, rse_pkg::OP_MUL, rse_pkg::Q_MAX);
      add_token(rse_pkg::MODE_PUSH, rse_pkg::OP_ADD, rse_pkg::Q_MAX);
      add_token(rse_pkg::MODE_OPER, rse_pkg::OP_DIV, '0);
      add_token(rse_pkg::MODE_PUSH, rse_pkg::OP_SUB, rse_pkg::Q_MAX);
      add_token(rse_pkg::MODE_OPER, rse_pkg::OP_ADD, '0);
      add_token(rse_pkg::MODE_PUSH, rse_pkg::OP_MUL, rse_pkg::Q_MIN);
      add_token(rse_pkg::MODE_OPER, rse_pkg::OP_SUB, '0);
      add_token(rse_pkg::MODE_PUSH, rse_pkg::OP_DIV, '0);
      add_token(rse_pkg::MODE_OPER, rse_pkg::OP_DIV, rse_pkg::Q_MIN);
      add_token(rse_pkg::MODE_OPER, rse_pkg::OP_MUL, '0);
      add_token(rse_pkg::MODE_PUSH, rse_pkg::OP_ADD, rse_pkg::Q_MIN);
      add_token(rse_pkg::MODE_OPER, rse_pkg::OP_SUB, '0);
      add_token(rse_pkg::MODE_PUSH, rse_pkg::OP_ADD, rse_pkg::Q_MIN);
      add_token(rse_pkg::MODE_OPER, rse_pkg::OP_ADD, '1);
      add_token(rse_pkg::MODE_PUSH, rse_pkg::OP_ADD, 32'h0000_0001);
      add_token(rse_pkg::MODE_OPER, rse_pkg::OP_DIV, '0);
      add_token(rse_pkg::MODE_PUSH, rse_pkg::OP_ADD, 32'hFFFF_FFFF);
      add_token(rse_pkg::MODE_OPER, rse_pkg::OP_MUL, '0);
      add_token(rse_pkg::MODE_PUSH, rse_pkg::OP_ADD, rse_pkg::Q_MIN);
      add_token(rse_pkg::MODE_PUSH, rse_pkg::OP_ADD, rse_pkg::Q_MIN);
      add_token(rse_pkg::MODE_OPER, rse_pkg::OP_MUL, '0);
      add_token(rse_pkg::MODE_NONE, rse_pkg::OP_DIV, '1);
      add_token(rse_pkg::MODE_FINISH, rse_pkg::OP_SUB, '0);

      n = pending_tokens.size();
      scenario = 0;
      while (pending_tokens.size() < n + RANDOM_ITEMS) begin
         if (scenario % 40 == 7) begin
            // push the stack up to or near its limit
            repeat ($urandom_range(60, 70)) begin
               add_token(rse_pkg::MODE_PUSH, any_op(), pick_number());
            end
            repeat (3) add_token(rse_pkg::MODE_OPER, any_op(), pick_number());
            add_token(rse_pkg::MODE_FINISH, any_op(), pick_number());
         end else if ($urandom_range(0, 99) < 12) begin
            repeat ($urandom_range(1, 6)) begin
               add_token(rse_pkg::mode_type'($urandom_range(0, 3)), any_op(), pick_number());
            end
         end else begin
            operands = $urandom_range(1, 8);
            pushed = 0;
            while (pushed < operands || plan_state.depth > 1) begin
               if (pushed < operands && (plan_state.depth < 2 || $urandom_range(0, 2) != 0)) begin
                  add_token(rse_pkg::MODE_PUSH, any_op(), pick_number());
                  pushed++;
               end else begin
                  add_token(rse_pkg::MODE_OPER, any_op(), pick_number());
               end
            end
            if ($urandom_range(0, 99) >= 15) begin
               add_token(rse_pkg::MODE_FINISH, any_op(), pick_number());
            end
         end
         scenario++;
      end

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      while (pending_tokens.size() != 0 || awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests in %0d sequences, %0d results checked, %0d divides, peak depth %0d",
               accepted, scenario, received, divides, peak_depth);
      $display("status mix: ok %0d, too few %0d, full %0d, divide by zero %0d, empty finish %0d",
               status_seen[rse_pkg::ST_OK], status_seen[rse_pkg::ST_FEW],
               status_seen[rse_pkg::ST_FULL], status_seen[rse_pkg::ST_DIV0],
               status_seen[rse_pkg::ST_EMPTY]);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
